/* hw/rtl/imh_pkg.sv */
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants for the indexed min-heap unit
// Sizes, command and status codes, and the request/response payload structs.
// ----------------------------------------------------------------------------
package imh_pkg;

   localparam int VERTICES  = 1024;
   localparam int SLOT_BITS = $clog2(VERTICES);
   localparam int CNT_BITS  = SLOT_BITS + 1;
   localparam int KEY_BITS  = 32;

   localparam logic [1:0] KIND_CLEAR    = 2'd0;
   localparam logic [1:0] KIND_OFFER    = 2'd1;
   localparam logic [1:0] KIND_POP      = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   localparam logic [2:0] STATUS_INSERTED  = 3'd0;
   localparam logic [2:0] STATUS_DECREASED = 3'd1;
   localparam logic [2:0] STATUS_IGNORED   = 3'd2;
   localparam logic [2:0] STATUS_POPPED    = 3'd3;
   localparam logic [2:0] STATUS_EMPTY     = 3'd4;
   localparam logic [2:0] STATUS_CLEARED   = 3'd5;

   typedef struct packed {
      logic [1:0]           kind;
      logic [9:0]           vertex_id;
      logic signed [31:0]   key;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [9:0]           popped_vertex;
      logic signed [31:0]   popped_key;
      logic [10:0]          occupancy;
   } rsp_type;

   // Key relations among the item key (a) and the two read keys (b, c)
   typedef struct packed {
      logic a_lt_b;
      logic b_lt_a;
      logic b_lt_c;
      logic c_lt_a;
   } cmp_type;

endpackage

/* hw/rtl/imh_ram.sv */
// ----------------------------------------------------------------------------
// imh_ram: one-write, two-read synchronous RAM
// Read data is registered; a read sees writes from earlier cycles.
// ----------------------------------------------------------------------------
module imh_ram #(
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr_a,
   input  logic [ADDR_BITS-1:0] raddr_b,
   output logic [WIDTH-1:0]     rdata_a,
   output logic [WIDTH-1:0]     rdata_b
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];

   // Write one entry, read two
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

/* hw/rtl/imh_cmp.sv */
// ----------------------------------------------------------------------------
// imh_cmp: shared signed key compare unit
// Orders the moving item key against the keys read from the two RAM ports.
// ----------------------------------------------------------------------------
module imh_cmp (
   input  logic [imh_pkg::KEY_BITS-1:0] key_a,
   input  logic [imh_pkg::KEY_BITS-1:0] key_b,
   input  logic [imh_pkg::KEY_BITS-1:0] key_c,
   output imh_pkg::cmp_type             rel
);
   import imh_pkg::*;

   // Compare as signed values
   always_comb begin
      rel.a_lt_b = $signed(key_a) < $signed(key_b);
      rel.b_lt_a = $signed(key_b) < $signed(key_a);
      rel.b_lt_c = $signed(key_b) < $signed(key_c);
      rel.c_lt_a = $signed(key_c) < $signed(key_a);
   end

endmodule

/* hw/rtl/indexed_min_heap_decrease_key_unit.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_unit: indexed binary min-heap with decrease-key
// Offer, pop and clear requests on a 1024-vertex heap with signed keys.
// ----------------------------------------------------------------------------
// After reset the unit loads the identity position maps and takes no
// request meanwhile. It then serves one request at a time. Clear, pop on an
// empty heap and unused kinds go straight to the response; an offer whose key
// is not smaller goes to the response after the compare, any other offer
// climbs the heap level by level, and a pop descends it level by level. A
// stalled response holds the unit until the response register frees up. Each
// level of the sift walk needs one registered read of the key and slot RAMs
// followed by one pass through the shared compare unit and one write.
module indexed_min_heap_decrease_key_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  imh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output imh_pkg::rsp_type rsp_data
);
   import imh_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_OFF_SLOT, S_OFF_CMP, S_INS_MAP, S_UP_CHK, S_UP_CMP,
      S_POP_RD, S_DN_CHK, S_DN_CMP, S_RESP
   } state_type;

   state_type              state_ff;
   logic [SLOT_BITS-1:0]   idx_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic [SLOT_BITS-1:0]   slot_ff;
   logic [SLOT_BITS-1:0]   cur_ff;
   logic [SLOT_BITS-1:0]   item_vid_ff;
   logic [KEY_BITS-1:0]    item_key_ff;
   logic [2:0]             status_ff;
   logic [SLOT_BITS-1:0]   pv_ff;
   logic [KEY_BITS-1:0]    pk_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic                   k_we, sv_we, vs_we;
   logic [SLOT_BITS-1:0]   k_wa, sv_wa, vs_wa, sv_wd, vs_wd;
   logic [KEY_BITS-1:0]    k_wd;
   logic [SLOT_BITS-1:0]   ra_a, ra_b, vs_ra;
   logic [KEY_BITS-1:0]    k_rd_a, k_rd_b;
   logic [SLOT_BITS-1:0]   sv_rd_a, sv_rd_b, vs_rd;
   cmp_type                rel;

   logic                   accept;
   logic [SLOT_BITS-1:0]   last_slot;
   logic [SLOT_BITS-1:0]   cur_m1;
   logic [SLOT_BITS-1:0]   parent;
   logic [CNT_BITS-1:0]    left_w;
   logic [CNT_BITS:0]      right_w;
   logic                   left_out;
   logic                   right_in;
   logic                   slot_in;
   logic                   dn_move;
   logic                   dn_right;
   logic [SLOT_BITS-1:0]   child;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Tree index arithmetic around the current slot
   assign last_slot = count_ff[SLOT_BITS-1:0] - 1'b1;
   assign cur_m1    = cur_ff - 1'b1;
   assign parent    = {1'b0, cur_m1[SLOT_BITS-1:1]};
   assign left_w    = {cur_ff, 1'b1};
   assign right_w   = {1'b0, cur_ff, 1'b0} + 2'd2;
   assign left_out  = left_w >= count_ff;
   assign right_in  = right_w < {1'b0, count_ff};
   assign slot_in   = {1'b0, vs_rd} < count_ff;

   // Pick the child to promote in sift-down; ties go right
   always_comb begin
      dn_move  = 1'b0;
      dn_right = 1'b0;
      if (right_in) begin
         if (rel.b_lt_a && rel.b_lt_c) begin
            dn_move = 1'b1;
         end else if (rel.c_lt_a) begin
            dn_move  = 1'b1;
            dn_right = 1'b1;
         end
      end else if (rel.b_lt_a) begin
         dn_move = 1'b1;
      end
   end
   assign child = dn_right ? right_w[SLOT_BITS-1:0] : left_w[SLOT_BITS-1:0];

   // Drive RAM ports from the sequencer state
   always_comb begin
      k_we  = 1'b0;  k_wa  = cur_ff;  k_wd  = item_key_ff;
      sv_we = 1'b0;  sv_wa = cur_ff;  sv_wd = item_vid_ff;
      vs_we = 1'b0;  vs_wa = item_vid_ff;  vs_wd = cur_ff;
      ra_a  = '0;    ra_b  = '0;      vs_ra = req_data.vertex_id;
      case (state_ff)
         S_INIT: begin
            sv_we = 1'b1;  sv_wa = idx_ff;  sv_wd = idx_ff;
            vs_we = 1'b1;  vs_wa = idx_ff;  vs_wd = idx_ff;
         end
         S_IDLE: begin
            ra_b = last_slot;
         end
         S_OFF_SLOT: begin
            ra_a = slot_in ? vs_rd : count_ff[SLOT_BITS-1:0];
         end
         S_INS_MAP: begin
            sv_we = 1'b1;  sv_wa = slot_ff;  sv_wd = sv_rd_a;
            vs_we = 1'b1;  vs_wa = sv_rd_a;  vs_wd = slot_ff;
         end
         S_UP_CHK: begin
            ra_a = parent;
            if (cur_ff == '0) begin
               k_we = 1'b1;  sv_we = 1'b1;  vs_we = 1'b1;
            end
         end
         S_UP_CMP: begin
            k_we = 1'b1;  sv_we = 1'b1;  vs_we = 1'b1;
            if (rel.a_lt_b) begin
               k_wd  = k_rd_a;
               sv_wd = sv_rd_a;
               vs_wa = sv_rd_a;
            end
         end
         S_POP_RD: begin
            k_we  = 1'b1;  k_wa  = last_slot;  k_wd  = k_rd_a;
            sv_we = 1'b1;  sv_wa = last_slot;  sv_wd = sv_rd_a;
            vs_we = 1'b1;  vs_wa = sv_rd_a;    vs_wd = last_slot;
         end
         S_DN_CHK: begin
            ra_a = left_w[SLOT_BITS-1:0];
            ra_b = right_w[SLOT_BITS-1:0];
            if (left_out) begin
               k_we = 1'b1;  sv_we = 1'b1;  vs_we = 1'b1;
            end
         end
         S_DN_CMP: begin
            k_we = 1'b1;  sv_we = 1'b1;  vs_we = 1'b1;
            if (dn_move) begin
               k_wd  = dn_right ? k_rd_b : k_rd_a;
               sv_wd = dn_right ? sv_rd_b : sv_rd_a;
               vs_wa = dn_right ? sv_rd_b : sv_rd_a;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer: state, counters and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == SLOT_BITS'(VERTICES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  item_vid_ff <= req_data.vertex_id;
                  item_key_ff <= req_data.key;
                  pv_ff       <= '0;
                  pk_ff       <= '0;
                  case (req_data.kind)
                     KIND_CLEAR: begin
                        count_ff  <= '0;
                        status_ff <= STATUS_CLEARED;
                        state_ff  <= S_RESP;
                     end
                     KIND_OFFER: begin
                        state_ff <= S_OFF_SLOT;
                     end
                     KIND_POP: begin
                        if (count_ff == '0) begin
                           status_ff <= STATUS_EMPTY;
                           state_ff  <= S_RESP;
                        end else begin
                           state_ff <= S_POP_RD;
                        end
                     end
                     default: begin
                        status_ff <= STATUS_IGNORED;
                        state_ff  <= S_RESP;
                     end
                  endcase
               end
            end
            S_OFF_SLOT: begin
               slot_ff  <= vs_rd;
               state_ff <= slot_in ? S_OFF_CMP : S_INS_MAP;
            end
            S_OFF_CMP: begin
               if (rel.a_lt_b) begin
                  cur_ff    <= slot_ff;
                  status_ff <= STATUS_DECREASED;
                  state_ff  <= S_UP_CHK;
               end else begin
                  status_ff <= STATUS_IGNORED;
                  state_ff  <= S_RESP;
               end
            end
            S_INS_MAP: begin
               cur_ff    <= count_ff[SLOT_BITS-1:0];
               status_ff <= STATUS_INSERTED;
               state_ff  <= S_UP_CHK;
            end
            S_UP_CHK: begin
               if (cur_ff == '0) begin
                  if (status_ff == STATUS_INSERTED) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_UP_CMP;
               end
            end
            S_UP_CMP: begin
               if (rel.a_lt_b) begin
                  cur_ff   <= parent;
                  state_ff <= S_UP_CHK;
               end else begin
                  if (status_ff == STATUS_INSERTED) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= S_RESP;
               end
            end
            S_POP_RD: begin
               pv_ff       <= sv_rd_a;
               pk_ff       <= k_rd_a;
               item_vid_ff <= sv_rd_b;
               item_key_ff <= k_rd_b;
               count_ff    <= count_ff - 1'b1;
               cur_ff      <= '0;
               status_ff   <= STATUS_POPPED;
               state_ff    <= S_DN_CHK;
            end
            S_DN_CHK: begin
               state_ff <= left_out ? S_RESP : S_DN_CMP;
            end
            S_DN_CMP: begin
               if (dn_move) begin
                  cur_ff   <= child;
                  state_ff <= S_DN_CHK;
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.status        <= status_ff;
                  rsp_data_ff.popped_vertex <= pv_ff;
                  rsp_data_ff.popped_key    <= pk_ff;
                  rsp_data_ff.occupancy     <= count_ff;
                  rsp_valid_ff              <= 1'b1;
                  state_ff                  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Key per slot
   imh_ram #(.WIDTH(KEY_BITS), .ADDR_BITS(SLOT_BITS)) u_key_ram (
      .clock   (clock),
      .we      (k_we),
      .waddr   (k_wa),
      .wdata   (k_wd),
      .raddr_a (ra_a),
      .raddr_b (ra_b),
      .rdata_a (k_rd_a),
      .rdata_b (k_rd_b)
   );

   // Vertex per slot
   imh_ram #(.WIDTH(SLOT_BITS), .ADDR_BITS(SLOT_BITS)) u_s2v_ram (
      .clock   (clock),
      .we      (sv_we),
      .waddr   (sv_wa),
      .wdata   (sv_wd),
      .raddr_a (ra_a),
      .raddr_b (ra_b),
      .rdata_a (sv_rd_a),
      .rdata_b (sv_rd_b)
   );

   // Slot per vertex
   imh_ram #(.WIDTH(SLOT_BITS), .ADDR_BITS(SLOT_BITS)) u_v2s_ram (
      .clock   (clock),
      .we      (vs_we),
      .waddr   (vs_wa),
      .wdata   (vs_wd),
      .raddr_a (vs_ra),
      .raddr_b (vs_ra),
      .rdata_a (vs_rd),
      .rdata_b ()
   );

   // Shared key compare unit
   imh_cmp u_cmp (
      .key_a (item_key_ff),
      .key_b (k_rd_a),
      .key_c (k_rd_b),
      .rel   (rel)
   );

endmodule
